// ===== rtl/stack_sort_sequencer_macros.svh =====
// ----------------------------------------------------------------------------
// stack sort sequencer assertion macros
// concurrent checks clocked on clk, disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef STACK_SORT_SEQUENCER_MACROS_SVH
`define STACK_SORT_SEQUENCER_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define SSS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define SSS_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SSS_ASSERT_IMP(label, ante, cons, msg)
`define SSS_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

// ===== rtl/sss_pkg.sv =====
// ----------------------------------------------------------------------------
// sss_pkg
// shared types and constants of the stack sort sequencer
// ----------------------------------------------------------------------------
package sss_pkg;

	localparam int STACK_DEPTH_DEF = 32;
	localparam int VALUE_W         = 32;

	// operation codes
	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	typedef struct packed {
		logic signed [VALUE_W-1:0] item_value;
		logic                      is_final;
	} item_t;

	typedef struct packed {
		logic                      op_kind;
		logic signed [VALUE_W-1:0] op_value;
		logic                      order_ok;
		logic                      overflow_seen;
		logic                      run_end;
		logic                      sequence_done;
	} op_t;

endpackage

// ===== rtl/stack_sort_sequencer.sv =====
// ----------------------------------------------------------------------------
// stack_sort_sequencer
// sorts a stream of signed values with one stack and streams the push/pop
// operations, with a running order check and an overflow flag
// ----------------------------------------------------------------------------
//  channel | ports                      | beat
//  --------+----------------------------+--------------------------------------
//  input   | item_valid, item_stall     | item: item_value, is_final
//  output  | op_valid, op_stall         | op: kind, value, flags, run_end, done
//
//  an item is accepted in idle, then each pop runs fetch, compare with the
//  item and emit; if entries remain, a fetch and a compare stop the pops
//  before the push; a final item then drains every entry by fetch and emit.
//  the single ram read port and the one shared signed comparator set these steps.
//  reset clears the stack count and the sequence flags; no ram clearing.
//  a stalled output holds the sequencer wherever a beat is to be emitted.
// ----------------------------------------------------------------------------
module stack_sort_sequencer #(
	parameter int STACK_DEPTH = sss_pkg::STACK_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_stall,
	input  sss_pkg::item_t item,
	output logic           op_valid,
	input  logic           op_stall,
	output sss_pkg::op_t   op
);

	`include "stack_sort_sequencer_macros.svh"

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(STACK_DEPTH);
	localparam logic [CW-1:0] ONE_CNT  = CW'(1);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_FETCH = 5'b00010,
		S_TEST  = 5'b00100,
		S_POP   = 5'b01000,
		S_PUSH  = 5'b10000
	} state_t;

	state_t state_q;

	// item under work
	logic signed [sss_pkg::VALUE_W-1:0] x_q;
	logic                               fin_q;
	logic                               drain_q;

	// stack and sequence state
	logic [CW-1:0]                      count_q;
	logic signed [sss_pkg::VALUE_W-1:0] last_q;
	logic                               any_q;
	logic                               order_q;
	logic                               ovf_q;

	// output register
	logic         out_valid_q;
	sss_pkg::op_t out_q;

	// ram port
	logic                        ram_we;
	logic                        ram_re;
	logic [AW-1:0]               ram_waddr;
	logic [AW-1:0]               ram_raddr;
	logic [sss_pkg::VALUE_W-1:0] ram_rdata;
	logic signed [sss_pkg::VALUE_W-1:0] top_val;

	// shared signed comparator
	logic signed [sss_pkg::VALUE_W-1:0] cmp_a;
	logic signed [sss_pkg::VALUE_W-1:0] cmp_b;
	logic                               cmp_lt;

	logic out_free;
	logic full;
	logic pop_viol;
	logic emit;

	assign top_val  = $signed(ram_rdata);
	assign out_free = !out_valid_q || !op_stall;
	assign full     = (count_q == FULL_CNT);

	// top of stack vs incoming value while testing, popped vs last popped
	// while popping
	assign cmp_a  = top_val;
	assign cmp_b  = (state_q == S_TEST) ? x_q : last_q;
	assign cmp_lt = (cmp_a < cmp_b);

	assign pop_viol = any_q && cmp_lt;

	assign emit = out_free && ((state_q == S_POP) || (state_q == S_PUSH));

	assign ram_re    = (state_q == S_FETCH);
	assign ram_raddr = AW'(count_q - ONE_CNT);
	assign ram_we    = (state_q == S_PUSH) && out_free && !full;
	assign ram_waddr = AW'(count_q);

	sss_ram #(
		.WIDTH (sss_pkg::VALUE_W),
		.DEPTH (STACK_DEPTH)
	) u_stack_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (x_q),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign item_stall = (state_q != S_IDLE);
	assign op_valid   = out_valid_q;
	assign op         = out_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			drain_q <= 1'b0;
			count_q <= '0;
			last_q  <= '0;
			any_q   <= 1'b0;
			order_q <= 1'b1;
			ovf_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						state_q <= (count_q == '0) ? S_PUSH : S_FETCH;
					end
				end
				S_FETCH: begin
					state_q <= drain_q ? S_POP : S_TEST;
				end
				S_TEST: begin
					state_q <= cmp_lt ? S_POP : S_PUSH;
				end
				S_POP: begin
					if (out_free) begin
						count_q <= count_q - ONE_CNT;
						if (drain_q && (count_q == ONE_CNT)) begin
							// last drained entry closes the sequence
							state_q <= S_IDLE;
							drain_q <= 1'b0;
							last_q  <= '0;
							any_q   <= 1'b0;
							order_q <= 1'b1;
							ovf_q   <= 1'b0;
						end else begin
							last_q  <= top_val;
							any_q   <= 1'b1;
							order_q <= order_q && !pop_viol;
							if (count_q == ONE_CNT) begin
								state_q <= S_PUSH;
							end else begin
								state_q <= S_FETCH;
							end
						end
					end
				end
				S_PUSH: begin
					if (out_free) begin
						if (full) begin
							ovf_q <= 1'b1;
						end else begin
							count_q <= count_q + ONE_CNT;
						end
						if (fin_q) begin
							drain_q <= 1'b1;
							state_q <= S_FETCH;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// incoming item, payload only
	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && item_valid) begin
			x_q   <= item.item_value;
			fin_q <= item.is_final;
		end
	end

	// output beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!op_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			if (state_q == S_POP) begin
				out_q.op_kind       <= sss_pkg::OP_POP;
				out_q.op_value      <= top_val;
				out_q.order_ok      <= order_q && !pop_viol;
				out_q.overflow_seen <= ovf_q;
				out_q.run_end       <= drain_q ? (count_q == ONE_CNT)
				                               : 1'b0;
				out_q.sequence_done <= drain_q && (count_q == ONE_CNT);
			end else begin
				out_q.op_kind       <= sss_pkg::OP_PUSH;
				out_q.op_value      <= x_q;
				out_q.order_ok      <= order_q;
				out_q.overflow_seen <= ovf_q || full;
				out_q.run_end       <= !fin_q;
				out_q.sequence_done <= 1'b0;
			end
		end
	end

	// checks
	`SSS_ASSERT_IMP(a_count_bound, 1'b1, count_q <= FULL_CNT, "stack count beyond depth")
	`SSS_ASSERT_IMP(a_done_ends_run, op_valid && op.sequence_done, op.run_end, "done without run end")
	`SSS_ASSERT_IMP(a_done_empty, op_valid && !op_stall && op.sequence_done, count_q == '0, "stack not empty at done")
	`SSS_ASSERT_NXT(a_pop_dec, (state_q == S_POP) && out_free, count_q == $past(count_q) - ONE_CNT, "pop did not shrink stack")

endmodule

// ===== rtl/sss_ram.sv =====
// ----------------------------------------------------------------------------
// sss_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module sss_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the stack sort sequencer: items go in through the
// valid/stall input channel, a local stack model predicts every push and pop
// beat with its flags, and each accepted op beat is compared field by field
// ----------------------------------------------------------------------------
module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH     = sss_pkg::STACK_DEPTH_DEF;
	localparam int VW        = sss_pkg::VALUE_W;
	localparam int HOLD_LEN  = 400;	// long receiver hold-off, in cycles
	localparam int IDLE_PCT  = 11;	// idle chance per cycle on each side
	localparam int TAIL_WAIT = 40;	// quiet cycles after the last beat

	// dut ports, the inputs all known from time zero
	logic           clk        = 1'b0;
	logic           arst_n     = 1'b0;
	logic           item_valid = 1'b0;
	logic           item_stall;
	sss_pkg::item_t item       = '0;
	logic           op_valid;
	logic           op_stall   = 1'b0;
	sss_pkg::op_t   op;

	// idling control shared by sender and receiver
	logic quiet      = 1'b0;	// high: no random idling on either side
	int   hold_token = 0;		// bumped by a test to request a hold-off
	int   hold_seen  = 0;
	int   hold_left  = 0;

	// stack model state
	logic signed [VW-1:0] stk_mem [DEPTH];
	int                   stk_used    = 0;
	logic signed [VW-1:0] prev_pop    = '0;
	logic                 popped_any  = 1'b0;
	logic                 order_good  = 1'b1;
	logic                 overflowed  = 1'b0;

	// op beats still to come, oldest first
	sss_pkg::op_t pending_ops [$];

	int mismatch_count = 0;
	int beat_no        = 0;

	stack_sort_sequencer uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.op_valid   (op_valid),
		.op_stall   (op_stall),
		.op         (op)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// hard stop in case the block hangs
	initial begin
		#5_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// ------------------------------------------------------------------------
	// stack model
	// ------------------------------------------------------------------------

	// queue one op beat carrying the current sequence flags
	function automatic void log_op(logic kind, logic signed [VW-1:0] v);
		sss_pkg::op_t o;
		o.op_kind       = kind;
		o.op_value      = v;
		o.order_ok      = order_good;
		o.overflow_seen = overflowed;
		o.run_end       = 1'b0;
		o.sequence_done = 1'b0;
		pending_ops.insert(pending_ops.size(), o);
	endfunction

	// pop the top entry; the very first pop of a sequence never breaks order
	function automatic void pop_top();
		logic signed [VW-1:0] v;
		stk_used--;
		v = stk_mem[stk_used];
		if (popped_any && v < prev_pop)
			order_good = 1'b0;
		prev_pop   = v;
		popped_any = 1'b1;
		log_op(sss_pkg::OP_POP, v);
	endfunction

	// all op beats caused by one accepted item
	function automatic void predict_stack_ops(sss_pkg::item_t it);
		logic signed [VW-1:0] v;
		sss_pkg::op_t         last_op;
		int                   last_idx;
		v = it.item_value;
		// strictly smaller entries leave first; equal ones stay
		while (stk_used > 0 && stk_mem[stk_used-1] < v)
			pop_top();
		// full stack drops the push but still reports it
		if (stk_used < DEPTH) begin
			stk_mem[stk_used] = v;
			stk_used++;
		end else begin
			overflowed = 1'b1;
		end
		log_op(sss_pkg::OP_PUSH, v);
		if (it.is_final) begin
			while (stk_used > 0)
				pop_top();
		end
		last_idx = pending_ops.size() - 1;
		last_op  = pending_ops[last_idx];
		last_op.run_end       = 1'b1;
		last_op.sequence_done = it.is_final;
		pending_ops[last_idx] = last_op;
		// a final item starts a fresh sequence afterwards
		if (it.is_final) begin
			prev_pop   = '0;
			popped_any = 1'b0;
			order_good = 1'b1;
			overflowed = 1'b0;
		end
	endfunction

	// ------------------------------------------------------------------------
	// receiver: random stalls, plus a long hold-off on request
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (hold_token != hold_seen) begin
			hold_seen <= hold_token;
			hold_left <= HOLD_LEN;
			op_stall  <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			op_stall  <= 1'b1;
		end else begin
			op_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
		end
	end

	// ------------------------------------------------------------------------
	// op beat checker
	// ------------------------------------------------------------------------
	function automatic void cmp_field(string name, logic [VW-1:0] want,
					  logic [VW-1:0] got);
		if (got !== want) begin
			$display("%0t op beat %0d: %s expected %0h actual %0h",
				 $time, beat_no, name, want, got);
			mismatch_count++;
		end
	endfunction

	always @(posedge clk) begin
		sss_pkg::op_t want;
		if (arst_n && op_valid && !op_stall) begin
			beat_no++;
			if (pending_ops.size() == 0) begin
				// nothing was due
				$display("%0t op beat %0d: expected none actual %h",
					 $time, beat_no, op);
				mismatch_count++;
			end else begin
				want = pending_ops.pop_front();
				cmp_field("op_kind",       want.op_kind,       op.op_kind);
				cmp_field("op_value",      want.op_value,      op.op_value);
				cmp_field("order_ok",      want.order_ok,      op.order_ok);
				cmp_field("overflow_seen", want.overflow_seen, op.overflow_seen);
				cmp_field("run_end",       want.run_end,       op.run_end);
				cmp_field("sequence_done", want.sequence_done, op.sequence_done);
			end
		end
	end

	// ------------------------------------------------------------------------
	// sender
	// ------------------------------------------------------------------------

	// offer one item and wait for its beat to be taken; valid stays high
	// afterwards so back-to-back items need no extra edge
	task automatic send_item(input logic signed [VW-1:0] v, input logic fin);
		sss_pkg::item_t beat;
		beat.item_value = v;
		beat.is_final   = fin;
		while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= beat;
		do @(posedge clk); while (item_stall);
		predict_stack_ops(beat);
	endtask

	// stop offering and wait until every predicted beat has arrived;
	// always waits on the clock before checking, so valid is never dropped and
	// raised in the same step
	task automatic drain_results();
		item_valid <= 1'b0;
		do @(posedge clk); while (pending_ops.size() != 0);
	endtask

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// extremes, equal values, first pop, order break, final reset of flags
	task automatic test_directed();
		// negative first pop is not a violation; equal entry is not popped
		send_item(-5, 1'b0);
		send_item(-3, 1'b0);
		send_item(-3, 1'b0);
		send_item(-4, 1'b1);
		// 1 popped after 5 breaks the order; verdict stays low to the end
		send_item(5, 1'b0);
		send_item(6, 1'b0);
		send_item(1, 1'b0);
		send_item(2, 1'b0);
		send_item(0, 1'b1);
		// new sequence after a failed verdict starts clean
		send_item(4, 1'b1);
		// value extremes, equal to bottom entry, min popped after zero
		send_item(32'sh7fff_ffff, 1'b0);
		send_item(32'sh8000_0000, 1'b0);
		send_item(0, 1'b0);
		send_item(32'sh7fff_ffff, 1'b0);
		send_item(32'sh8000_0000, 1'b1);
		// lone final item on an empty stack
		send_item(0, 1'b1);
	endtask

	// descending run fills the stack, extra pushes are dropped and flagged,
	// then the flag clears for the next sequence
	task automatic test_overflow();
		int i;
		for (i = 0; i < DEPTH + 3; i++)
			send_item(1000 - i, 1'b0);
		send_item(-1000, 1'b1);
		send_item(7, 1'b1);
	endtask

	// receiver holds off while the sender keeps offering, so the block backs
	// up and stalls its input; then the sender waits for everything
	task automatic test_backpressure();
		int i;
		hold_token <= hold_token + 1;
		for (i = 0; i < 12; i++)
			send_item((i % 3 == 0) ? 50 - i : i * 4, (i == 11));
		drain_results();
	endtask

	// mostly well-formed sequences ending in a final item, with random content
	task automatic test_random_sequences(input int n_items);
		int                   sent;
		int                   len;
		int                   mode;
		int                   i;
		logic signed [VW-1:0] v;
		sent = 0;
		while (sent < n_items) begin
			// no idling on either side for the first stretch
			quiet <= (sent < 30);
			len  = ($urandom_range(0, 11) == 0) ? $urandom_range(DEPTH - 2, DEPTH + 3)
							     : $urandom_range(1, 10);
			mode = $urandom_range(0, 3);
			for (i = 0; i < len; i++) begin
				case (mode)
				0: begin
					// narrow range: many equal values and pops
					v = $signed($urandom_range(0, 15)) - 8;
				end
				1: begin
					// non-decreasing: each item pops its predecessor unless the two are equal
					v = i * 3 + $signed($urandom_range(0, 3)) - 40;
				end
				2: begin
					// descending: stack grows, drained at the end
					v = 200 - i * 2;
				end
				default: begin
					// full range with the odd extreme
					case ($urandom_range(0, 7))
					0:       v = 32'sh8000_0000;
					1:       v = 32'sh7fff_ffff;
					default: v = $urandom;
					endcase
				end
				endcase
				send_item(v, (i == len - 1));
				sent++;
			end
		end
		quiet <= 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// run
	// ------------------------------------------------------------------------
	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		drain_results();
		test_overflow();
		drain_results();
		test_backpressure();
		test_random_sequences(40);

		// everything offered: wait for the tail, then watch for stray beats
		drain_results();
		repeat (TAIL_WAIT) @(posedge clk);

		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
